### rtl/mgtmi_pkg.sv
// shared types and codes for the matrix table multiply and inverse unit
`timescale 1ns / 1ps
package mgtmi_pkg;

    localparam int LANES = 4;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_MUL  = 2'd1,
        MODE_INV  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_OPERAND  = 2'd2,
        ST_ORDER    = 2'd3
    } status_t;

    typedef enum logic {
        CFG_ENTRY_COUNT = 1'b0,
        CFG_TOLERANCE   = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOADA,
        S_LOADB,
        S_MUL,
        S_MULW,
        S_ICHK,
        S_SEARCH,
        S_FINISH
    } state_t;

    // one multiply-accumulate step handed to every lane
    typedef struct packed {
        logic       en;
        logic       first;
        logic       last;
        logic [1:0] row;
    } mac_ctrl_t;

    // one finished product element from a lane
    typedef struct packed {
        logic              valid;
        logic [1:0]        row;
        logic signed [15:0] value;
    } mac_res_t;

endpackage

### rtl/matrix_group_table_mul_inv_unit.sv
// top level: matrix table with multiply and inverse lookup
`timescale 1ns / 1ps
// usage
//   s_axis carries one item per transaction: tuser is the mode, tdata the
//   entry, row, four row elements and the two operands. a load writes one
//   row of one entry. a multiply forms a*b and searches the loaded entries
//   for the first one within tolerance. an inverse raises a to powers until
//   the identity is hit and looks up the power before it.
//   m_axis returns one transaction per item: result index and status.
//   cfg writes entry_count (index 0) or match_tolerance (index 1), always ready.
// flow
//   one item at a time. a load or a rejected operand goes straight to the finish step.
//   a multiply loads a and b, runs the mac loop and a drain, then searches,
//   the four lanes stepping one row of one entry per read cycle.
//   an inverse repeats per power the 16-step mac loop of the lanes, a
//   drain and the identity check, up to max_order powers, and searches
//   once the identity is hit. the result sits in an output register, so the next item is
//   taken while it waits; a stalled receiver only holds a finished item
//   back from leaving the finish step.
// reset
//   clears control, entry_count to 0 and match_tolerance to 164, not the table:
//   the user must read entries only after they were loaded; the block does not enforce it.
module matrix_group_table_mul_inv_unit #(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_ORDER   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // entry_index[4:0] row_index[6:5] elem0[22:7] elem1[38:23]
    // elem2[54:39] elem3[70:55] operand_a[75:71] operand_b[80:76]
    input  logic [87:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_index[4:0] status[6:5]
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import mgtmi_pkg::*;

    localparam int DEPTH = MAX_ENTRIES * 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(MAX_ORDER + 1);

    state_t state_reg, state_next;

    logic [5:0]  entry_count_reg;
    logic [14:0] tol_reg;
    mode_t       mode_reg;
    logic [4:0]  opa_reg, opb_reg;
    logic [3:0]  cnt_reg;
    logic [OW-1:0] ocnt_reg;
    logic [5:0]  se_reg, e_d_reg;
    logic [1:0]  sr_reg, r_d_reg;
    logic        v_d_reg, eok_reg;
    logic [4:0]  res_idx_reg;
    status_t     res_st_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;

    // working matrices: left operand, right operand, product, search target
    logic signed [15:0] l_reg [16];
    logic signed [15:0] r_reg [16];
    logic signed [15:0] c_reg [16];
    logic signed [15:0] t_reg [16];

    // input fields
    logic        acc_in;
    mode_t       in_mode;
    logic [4:0]  in_ei, in_a, in_b;
    logic [1:0]  in_row;
    logic signed [15:0] in_elem [LANES];

    logic [5:0]  live_n;
    logic        bad_a, bad_b, ei_ok;
    logic        ident;
    logic        issue, all_ok, row_ok, hit, miss;
    logic        load_cap;
    logic [1:0]  cap_row;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    mac_ctrl_t       ctrl;
    logic signed [15:0] a_elem;
    logic signed [15:0] rd_data [LANES];
    mac_res_t        lane_res [LANES];
    logic [LANES-1:0] lane_ok;

    assign acc_in    = s_axis_tvalid && s_axis_tready;
    assign in_mode   = mode_t'(s_axis_tuser);
    assign in_ei     = s_axis_tdata[4:0];
    assign in_row    = s_axis_tdata[6:5];
    assign in_elem[0] = signed'(s_axis_tdata[22:7]);
    assign in_elem[1] = signed'(s_axis_tdata[38:23]);
    assign in_elem[2] = signed'(s_axis_tdata[54:39]);
    assign in_elem[3] = signed'(s_axis_tdata[70:55]);
    assign in_a      = s_axis_tdata[75:71];
    assign in_b      = s_axis_tdata[80:76];

    // a count above the table size acts as the table size
    assign live_n = (9'(entry_count_reg) > 9'(MAX_ENTRIES)) ? 6'(MAX_ENTRIES)
                                                          : entry_count_reg;
    assign bad_a  = {1'b0, in_a} >= live_n;
    assign bad_b  = {1'b0, in_b} >= live_n;
    assign ei_ok  = 9'(in_ei) < 9'(MAX_ENTRIES);

    // current power against the identity, all sixteen elements at once
    always_comb
    begin
        logic signed [16:0] d;
        logic [16:0]        m;
        ident = 1'b1;
        for (int k = 0; k < 16; k++)
        begin
            d = 17'(l_reg[k]) - (((k % 5) == 0) ? 17'sd16384 : 17'sd0);
            m = d[16] ? 17'(-d) : 17'(d);
            if (m > {2'b00, tol_reg})
                ident = 1'b0;
        end
    end

    // merge stage: a row matches when every lane matches
    assign issue   = (state_reg == S_SEARCH) && (se_reg < live_n);
    assign all_ok  = &lane_ok;
    assign row_ok  = ((r_d_reg == 2'd0) ? 1'b1 : eok_reg) && all_ok;
    assign hit     = v_d_reg && (r_d_reg == 2'd3) && row_ok;
    assign miss    = v_d_reg && (r_d_reg == 2'd3) && !row_ok && (e_d_reg == live_n - 6'd1);

    assign load_cap = ((state_reg == S_LOADA) || (state_reg == S_LOADB)) && (cnt_reg != 4'd0);
    assign cap_row  = 2'(cnt_reg - 4'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (in_mode == MODE_MUL && !bad_a && !bad_b)
                        state_next = S_LOADA;
                    else if (in_mode == MODE_INV && !bad_a)
                        state_next = S_LOADA;
                    else
                        state_next = S_FINISH;
                end
            end
            S_LOADA:
            begin
                if (cnt_reg == 4'd4)
                    state_next = (mode_reg == MODE_MUL) ? S_LOADB : S_ICHK;
            end
            S_LOADB:
            begin
                if (cnt_reg == 4'd4)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == 4'd15)
                    state_next = S_MULW;
            end
            S_MULW:
            begin
                if (cnt_reg == 4'd2)
                    state_next = (mode_reg == MODE_MUL) ? S_SEARCH : S_ICHK;
            end
            S_ICHK:
            begin
                if (ident)
                    state_next = S_SEARCH;
                else if (ocnt_reg == OW'(MAX_ORDER))
                    state_next = S_FINISH;
                else
                    state_next = S_MUL;
            end
            S_SEARCH:
            begin
                if (hit || miss)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        cfg_ready     = 1'b1;
        wr_en         = acc_in && (in_mode == MODE_LOAD) && ei_ok;
        wr_addr       = AW'({1'b0, in_ei, in_row});
        ctrl          = '0;
        a_elem        = l_reg[cnt_reg];
        rd_addr       = '0;
        unique case (state_reg)
            S_LOADA:  rd_addr = AW'({1'b0, opa_reg, cnt_reg[1:0]});
            S_LOADB:  rd_addr = AW'({1'b0, opb_reg, cnt_reg[1:0]});
            S_SEARCH: rd_addr = AW'({se_reg, sr_reg});
            S_MUL:
            begin
                ctrl.en    = 1'b1;
                ctrl.first = (cnt_reg[1:0] == 2'd0);
                ctrl.last  = (cnt_reg[1:0] == 2'd3);
                ctrl.row   = cnt_reg[3:2];
            end
            default: rd_addr = '0;
        endcase
    end

    // lanes, one per matrix column
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        mgtmi_lane #(.DEPTH(DEPTH)) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (in_elem[j]),
            .rd_addr (rd_addr),
            .rd_data (rd_data[j]),
            .ctrl    (ctrl),
            .a_elem  (a_elem),
            .b_elem  (r_reg[{cnt_reg[1:0], 2'(j)}]),
            .res     (lane_res[j]),
            .target  (t_reg[{r_d_reg, 2'(j)}]),
            .tol     (tol_reg),
            .ok      (lane_ok[j])
        );
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            tol_reg         <= 15'd164;
            cnt_reg         <= '0;
            ocnt_reg        <= '0;
            se_reg          <= '0;
            sr_reg          <= '0;
            v_d_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0)
            begin
                if (cfg_reg_t'(cfg_index[0]) == CFG_ENTRY_COUNT)
                    entry_count_reg <= cfg_data[5:0];
                else
                    tol_reg <= cfg_data;
            end

            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 4'd1;

            if (state_reg == S_LOADA && state_next == S_ICHK)
                ocnt_reg <= OW'(1);
            else if (state_reg == S_MULW && state_next == S_ICHK)
                ocnt_reg <= ocnt_reg + OW'(1);

            if (state_reg != S_SEARCH)
            begin
                se_reg  <= '0;
                sr_reg  <= '0;
                v_d_reg <= 1'b0;
            end
            else
            begin
                v_d_reg <= issue && !hit && !miss;
                if (issue)
                begin
                    sr_reg <= sr_reg + 2'd1;
                    if (sr_reg == 2'd3)
                        se_reg <= se_reg + 6'd1;
                end
            end

            // a finished item enters the output register once it is free
            if (state_reg == S_FINISH && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            mode_reg    <= in_mode;
            opa_reg     <= in_a;
            opb_reg     <= in_b;
            res_idx_reg <= '0;
            if ((in_mode == MODE_MUL && (bad_a || bad_b)) || (in_mode == MODE_INV && bad_a))
                res_st_reg <= ST_OPERAND;
            else
                res_st_reg <= ST_OK;
        end

        if (load_cap)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                if (state_reg == S_LOADB)
                    r_reg[{cap_row, 2'(j)}] <= rd_data[j];
                else
                begin
                    l_reg[{cap_row, 2'(j)}] <= rd_data[j];
                    if (mode_reg == MODE_INV)
                    begin
                        r_reg[{cap_row, 2'(j)}] <= rd_data[j];
                        t_reg[{cap_row, 2'(j)}] <= rd_data[j];
                    end
                end
            end
        end

        for (int j = 0; j < LANES; j++)
        begin
            if (lane_res[j].valid)
                c_reg[{lane_res[j].row, 2'(j)}] <= lane_res[j].value;
        end

        if (state_reg == S_MULW && cnt_reg == 4'd2)
        begin
            for (int k = 0; k < 16; k++)
            begin
                if (mode_reg == MODE_MUL)
                    t_reg[k] <= c_reg[k];
                else
                    l_reg[k] <= c_reg[k];
            end
        end

        // keep the power that precedes the next one
        if (state_reg == S_ICHK)
        begin
            if (!ident && ocnt_reg == OW'(MAX_ORDER))
                res_st_reg <= ST_ORDER;
            else if (!ident)
            begin
                for (int k = 0; k < 16; k++)
                    t_reg[k] <= l_reg[k];
            end
        end

        if (state_reg == S_SEARCH)
        begin
            e_d_reg <= se_reg;
            r_d_reg <= sr_reg;
            if (v_d_reg)
                eok_reg <= row_ok;
            if (hit)
            begin
                res_idx_reg <= e_d_reg[4:0];
                res_st_reg  <= ST_OK;
            end
            else if (miss)
            begin
                res_idx_reg <= '0;
                res_st_reg  <= ST_NO_MATCH;
            end
        end

        if (state_reg == S_FINISH && (!out_valid_reg || m_axis_tready))
            out_data_reg <= {1'b0, res_st_reg, res_idx_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule

### rtl/mgtmi_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module mgtmi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### rtl/mgtmi_lane.sv
// one column lane: column store, multiply-accumulate and element compare
`timescale 1ns / 1ps
module mgtmi_lane #(
    parameter int DEPTH = 128
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic signed [15:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic signed [15:0]        rd_data,
    input  mgtmi_pkg::mac_ctrl_t      ctrl,
    input  logic signed [15:0]        a_elem,
    input  logic signed [15:0]        b_elem,
    output mgtmi_pkg::mac_res_t       res,
    input  logic signed [15:0]        target,
    input  logic [14:0]               tol,
    output logic                      ok
);
    import mgtmi_pkg::*;

    logic [15:0]        rd_raw;
    mac_ctrl_t          s1_reg;
    logic signed [31:0] prod_reg;
    logic signed [33:0] acc_reg;
    logic signed [33:0] sum;
    logic signed [33:0] rnd;
    logic signed [19:0] q;
    logic signed [15:0] sat;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic               res_valid_reg;
    logic [1:0]         res_row_reg;
    logic signed [15:0] res_value_reg;

    mgtmi_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );
    assign rd_data = signed'(rd_raw);

    // round half up, floor shift, saturate
    always_comb
    begin
        sum = s1_reg.first ? 34'(prod_reg) : acc_reg + 34'(prod_reg);
        rnd = sum + 34'sd8192;
        q   = rnd[33:14];
        if (q > 20'sd32767)
            sat = 16'sh7fff;
        else if (q < -20'sd32768)
            sat = -16'sh8000;
        else
            sat = q[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg        <= ctrl;
            res_valid_reg <= s1_reg.en && s1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_elem * b_elem;
        if (s1_reg.en)
        begin
            acc_reg <= sum;
            if (s1_reg.last)
            begin
                res_value_reg <= sat;
                res_row_reg   <= s1_reg.row;
            end
        end
    end

    assign res = '{valid: res_valid_reg, row: res_row_reg, value: res_value_reg};

    always_comb
    begin
        diff = 17'(rd_data) - 17'(target);
        mag  = diff[16] ? 17'(-diff) : 17'(diff);
        ok   = mag <= {2'b00, tol};
    end
endmodule

### rtl/mgtmi_checker.sv
// port-level checks for the matrix table unit, bound to the top level
`timescale 1ns / 1ps
module mgtmi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    // a waiting result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // error statuses carry index zero
    a_err_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6:5] != 2'd0 |-> m_axis_tdata[4:0] == 5'd0)
        else $error("nonzero index with error status");

    // one item at a time: busy right after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");
endmodule

bind matrix_group_table_mul_inv_unit mgtmi_checker u_mgtmi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
